// ===== rtl/core/deque_with_search_assert.svh =====
// Assertion macros for the deque with search block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DEQUE_WITH_SEARCH_ASSERT_SVH
`define DEQUE_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define DQS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define DQS_ASSERT(label, clk, rst_n, prop, msg)
`define DQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dqs_pkg.sv =====
// Package for the deque with search: sizes, item structs, action and status codes,
// and the cell control types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_SEARCH     = 3'd4;
    localparam logic [2:0] ACT_SIZE       = 3'd5;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic [3:0]               found_index;
        logic [4:0]               entry_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_APPEND,
        CELL_DROP_TAIL
    } t_cell_op;

    // Broadcast to every cell
    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] operand;
    } t_cell_ctrl;

    // Status reported by every cell
    typedef struct packed {
        logic occ;
        logic match;
        logic tail;
    } t_cell_view;

endpackage

`default_nettype wire

// ===== rtl/core/deque_with_search.sv =====
// An accepted item's result is registered in the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled; every cell shifts, appends or compares in parallel.
// An item is taken whenever the output register is empty or being drained.
// Reset clears the occupied flags, the entry count and the output valid;
// stored values are not cleared. Depends on dqs_pkg, dqs_cell and deque_with_search_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_search_assert.svh"

module deque_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dqs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dqs_pkg::t_out_item o_out_item
);
    import dqs_pkg::*;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_ctrl               w_ctrl;
    t_cell_op                 w_op;
    logic signed [DATA_W-1:0] w_data [DEPTH];
    t_cell_view               w_view [DEPTH];
    logic [DEPTH-1:0]         w_occ;
    logic [DEPTH-1:0]         w_match;
    logic [DEPTH-1:0]         w_tail;
    logic signed [DATA_W-1:0] w_tail_data;
    logic [IDX_W-1:0]         w_hit_idx;
    logic                     w_hit;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    t_out_item                w_result;
    t_out_item                r_out_item;
    logic                     r_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = w_occ[DEPTH-1];
    assign w_empty    = !w_occ[0];

    // Chain of cells, front at cell zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev_data;
        logic signed [DATA_W-1:0] w_next_data;
        logic                     w_prev_occ;
        logic                     w_next_occ;

        if (g == 0) begin : g_front
            assign w_prev_data = i_in_item.operand_value;
            assign w_prev_occ  = 1'b1;
        end else begin : g_inner_prev
            assign w_prev_data = w_data[g-1];
            assign w_prev_occ  = w_occ[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign w_next_data = '0;
            assign w_next_occ  = 1'b0;
        end else begin : g_inner_next
            assign w_next_data = w_data[g+1];
            assign w_next_occ  = w_occ[g+1];
        end

        dqs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_prev_data (w_prev_data),
            .i_prev_occ  (w_prev_occ),
            .i_next_data (w_next_data),
            .i_next_occ  (w_next_occ),
            .o_data      (w_data[g]),
            .o_view      (w_view[g])
        );

        assign w_occ[g]   = w_view[g].occ;
        assign w_match[g] = w_view[g].match;
        assign w_tail[g]  = w_view[g].tail;
    end

    // Gather the back value and the first match from the front
    always_comb begin
        w_tail_data = '0;
        w_hit_idx   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_tail[i]) begin
                w_tail_data = w_tail_data | w_data[i];
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = IDX_W'(i);
            end
        end
    end
    assign w_hit = |w_match;

    // Decode the action into a cell command and a result
    always_comb begin
        w_op                  = CELL_HOLD;
        n_count               = r_count;
        w_result.status       = STAT_OK;
        w_result.result_value = '0;
        w_result.found_index  = '0;
        case (i_in_item.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (w_full) begin
                    w_result.status = STAT_FULL;
                end else begin
                    w_op    = (i_in_item.action == ACT_PUSH_FRONT) ? CELL_SHIFT_BACK
                                                                  : CELL_APPEND;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (w_empty) begin
                    w_result.status = STAT_EMPTY;
                end else begin
                    w_op                  = CELL_SHIFT_FRONT;
                    n_count               = r_count - 1'b1;
                    w_result.result_value = w_data[0];
                end
            end
            ACT_POP_BACK: begin
                if (w_empty) begin
                    w_result.status = STAT_EMPTY;
                end else begin
                    w_op                  = CELL_DROP_TAIL;
                    n_count               = r_count - 1'b1;
                    w_result.result_value = w_tail_data;
                end
            end
            ACT_SEARCH: begin
                if (w_hit) begin
                    w_result.found_index = 4'(w_hit_idx);
                end else begin
                    w_result.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                w_op = CELL_HOLD;
            end
        endcase
        w_result.entry_count = 5'(n_count);
    end

    assign w_ctrl.op      = w_accept ? w_op : CELL_HOLD;
    assign w_ctrl.operand = i_in_item.operand_value;

    // Entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `DQS_ASSERT(a_count_matches_cells, i_clk, i_rst_n, r_count == CNT_W'($countones(w_occ)), "entry count differs from occupied cells")
    `DQS_ASSERT(a_occ_contiguous, i_clk, i_rst_n, ((w_occ + 1'b1) & w_occ) == '0, "occupied cells not packed at the front")
    `DQS_ASSERT(a_full_means_depth, i_clk, i_rst_n, !(o_out_valid && o_out_item.status == STAT_FULL) || o_out_item.entry_count == 5'(DEPTH), "full status with free cells")
    `DQS_ASSERT_NEXT(a_push_front_lands, i_clk, i_rst_n, w_accept && i_in_item.action == ACT_PUSH_FRONT && !w_full, w_occ[0] && w_data[0] == $past(i_in_item.operand_value), "front push value not at cell zero")

endmodule

`default_nettype wire

// ===== rtl/core/dqs_cell.sv =====
// One storage cell of the deque chain: a value, an occupied flag and a key compare.
// Depends on dqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqs_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dqs_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [dqs_pkg::DATA_W-1:0] i_prev_data,
    input  logic                             i_prev_occ,
    input  logic signed [dqs_pkg::DATA_W-1:0] i_next_data,
    input  logic                             i_next_occ,
    output logic signed [dqs_pkg::DATA_W-1:0] o_data,
    output dqs_pkg::t_cell_view              o_view
);
    import dqs_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_occ;
    logic                     n_occ;

    // Pick the next content from the neighbors or the operand
    always_comb begin
        n_data = r_data;
        n_occ  = r_occ;
        case (i_ctrl.op)
            CELL_SHIFT_BACK: begin
                n_data = i_prev_data;
                n_occ  = i_prev_occ;
            end
            CELL_SHIFT_FRONT: begin
                n_data = i_next_data;
                n_occ  = i_next_occ;
            end
            CELL_APPEND: begin
                if (!r_occ && i_prev_occ) begin
                    n_data = i_ctrl.operand;
                    n_occ  = 1'b1;
                end
            end
            CELL_DROP_TAIL: begin
                if (r_occ && !i_next_occ) begin
                    n_occ = 1'b0;
                end
            end
            default: begin
                n_data = r_data;
                n_occ  = r_occ;
            end
        endcase
    end

    // Occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Value
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Report contents and compare against the key
    assign o_data       = r_data;
    assign o_view.occ   = r_occ;
    assign o_view.match = r_occ && (r_data == i_ctrl.operand);
    assign o_view.tail  = r_occ && !i_next_occ;

endmodule

`default_nettype wire
